// File: rtl/drfl_pkg.sv
// ----------------------------------------------------------------------------
// drfl_pkg: shared types and constants for the dated rate floor lookup
// Widths, status codes, command and status structs, month length table.
// ----------------------------------------------------------------------------
package drfl_pkg;

  // table geometry
  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int YEAR_W        = 14;
  localparam int MONTH_W       = 7;
  localparam int DAY_W         = 7;
  localparam int AMOUNT_W      = 32;
  localparam int RATE_W        = 40;
  localparam int STATUS_W      = 3;
  localparam int PRODUCT_W     = 49;
  localparam int KEY_W         = YEAR_W + 4 + 5;
  localparam int MAG_AMT_W     = AMOUNT_W - 1;
  localparam int MAG_RATE_W    = RATE_W - 1;

  // fixed point and product split
  localparam int FRACTION_BITS = 16;
  localparam int LO_W          = 32;
  localparam int HI_W          = MAG_RATE_W - LO_W;
  localparam int PLO_W         = MAG_AMT_W + LO_W;
  localparam int PHI_W         = MAG_AMT_W + HI_W;
  localparam int FULL_W        = MAG_AMT_W + MAG_RATE_W;

  // year / 100 by reciprocal multiply
  localparam int CENT_SHIFT    = 20;
  localparam int CENT_RECIP    = (1 << CENT_SHIFT) / 100 + 1;
  localparam int CENT_W        = 8;
  localparam int YSCALE_W      = YEAR_W + CENT_SHIFT - 5;
  localparam int YCHK_W        = YEAR_W + 1;

  // limits
  localparam logic [YEAR_W-1:0]    YEAR_MAX         = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0]   MONTH_MAX        = MONTH_W'(12);
  localparam logic [MAG_AMT_W-1:0] MAX_AMOUNT_RESET = MAG_AMT_W'(65536000);

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEG_AMOUNT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_RATE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NEG_RATE   = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic                capture;
    logic                scan_start;
    logic                scan_run;
    logic                write_hit;
    logic                write_new;
    logic                mul_lo;
    logic                mul_hi;
    logic                emit;
    logic                emit_product;
    logic [STATUS_W-1:0] code;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_query;
    logic date_ok;
    logic amt_neg;
    logic amt_big;
    logic rate_neg;
    logic scan_done;
    logic found;
    logic match;
    logic full;
  } dp_stat_t;

  // days in month, February by leap flag; invalid months give zero
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/drfl_ctrl.sv
// ----------------------------------------------------------------------------
// drfl_ctrl: sequencing state machine
// Steps one transaction through check, table scan, update and multiply.
// ----------------------------------------------------------------------------
module drfl_ctrl import drfl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_MUL_HI = 3'd4;
  localparam logic [2:0] S_SUM    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat.date_ok) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_BAD_DATE;
          state_next = S_IDLE;
        end else if (stat.is_query && stat.amt_neg) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_NEG_AMOUNT;
          state_next = S_IDLE;
        end else if (stat.is_query && stat.amt_big) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_TOO_LARGE;
          state_next = S_IDLE;
        end else if (!stat.is_query && stat.rate_neg) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_NEG_RATE;
          state_next = S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        priority if (stat.is_query && !stat.found) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_NO_RATE;
          state_next = S_IDLE;
        end else if (stat.is_query) begin
          cmd.mul_lo = 1'b1;
          state_next = S_MUL_HI;
        end else if (stat.match) begin
          cmd.write_hit = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.full) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.write_new = 1'b1;
          cmd.emit      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.emit         = 1'b1;
        cmd.emit_product = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/drfl_datapath.sv
// ----------------------------------------------------------------------------
// drfl_datapath: date check, rate table, floor scan and scaled multiply
// Table entries are kept in arrival order; the scan finds the floor entry.
// ----------------------------------------------------------------------------
module drfl_datapath import drfl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  ctl_cmd_t                    cmd,
  output dp_stat_t                    stat,
  input  logic                        mode,
  input  logic [YEAR_W-1:0]           year,
  input  logic [MONTH_W-1:0]          month,
  input  logic [DAY_W-1:0]            day,
  input  logic signed [AMOUNT_W-1:0]  amount,
  input  logic signed [RATE_W-1:0]    rate,
  input  logic                        cfg_we,
  input  logic [MAG_AMT_W-1:0]        cfg_data,
  output logic                        done,
  output logic [STATUS_W-1:0]         status,
  output logic [PRODUCT_W-1:0]        product
);

  // captured transaction
  logic                   mode_q;
  logic [YEAR_W-1:0]      year_q;
  logic [MONTH_W-1:0]     month_q;
  logic [DAY_W-1:0]       day_q;
  logic [AMOUNT_W-1:0]    amount_q;
  logic [RATE_W-1:0]      rate_q;
  logic [CENT_W-1:0]      cent_q;
  logic [YSCALE_W-1:0]    year_scaled;

  logic [MAG_AMT_W-1:0]   max_amount;

  // table storage
  logic [KEY_W-1:0]       key_mem  [TABLE_DEPTH];
  logic [MAG_RATE_W-1:0]  rate_mem [TABLE_DEPTH];
  logic [CNT_W-1:0]       count;
  logic [ADDR_W-1:0]      wr_addr;

  // scan state
  logic [CNT_W-1:0]       scan_idx;
  logic                   rd_vld;
  logic [ADDR_W-1:0]      rd_addr;
  logic [KEY_W-1:0]       key_rd;
  logic [MAG_RATE_W-1:0]  rate_rd;
  logic                   found;
  logic                   match;
  logic [ADDR_W-1:0]      match_addr;
  logic [KEY_W-1:0]       best_key;
  logic [MAG_RATE_W-1:0]  best_rate;

  // multiply
  logic [LO_W-1:0]        mul_b;
  logic [PLO_W-1:0]       mul_p;
  logic [PLO_W-1:0]       p_lo;
  logic [PHI_W-1:0]       p_hi;
  logic [FULL_W-1:0]      full_sum;
  logic [FULL_W-1:0]      shifted;
  logic [PRODUCT_W-1:0]   prod_sat;

  // date check
  logic                   century;
  logic                   leap;
  logic [4:0]             mlen;
  logic                   date_ok;
  logic [KEY_W-1:0]       qkey;

  // year / 100 ahead of the check
  assign year_scaled = YSCALE_W'(year) * YSCALE_W'(CENT_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      year_q   <= year;
      month_q  <= month;
      day_q    <= day;
      amount_q <= amount;
      rate_q   <= rate;
      cent_q   <= year_scaled[CENT_SHIFT +: CENT_W];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_amount <= MAX_AMOUNT_RESET;
    end else if (cfg_we) begin
      max_amount <= cfg_data;
    end
  end

  // Gregorian date validation
  assign century = ((YCHK_W'(cent_q) * YCHK_W'(100)) == YCHK_W'(year_q));
  assign leap    = (year_q[1:0] == 2'b00) && (!century || (cent_q[1:0] == 2'b00));
  assign mlen    = month_days(month_q[3:0], leap);
  assign date_ok = (year_q != '0) && (year_q <= YEAR_MAX) &&
                   (month_q != '0) && (month_q <= MONTH_MAX) &&
                   (day_q != '0) && (day_q <= DAY_W'(mlen));
  assign qkey    = {year_q, month_q[3:0], day_q[4:0]};

  // table writes: overwrite on hit, append otherwise
  assign wr_addr = cmd.write_hit ? match_addr : count[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write_hit || cmd.write_new) begin
      rate_mem[wr_addr] <= rate_q[MAG_RATE_W-1:0];
    end
    if (cmd.write_new) begin
      key_mem[wr_addr] <= qkey;
    end
    key_rd  <= key_mem[scan_idx[ADDR_W-1:0]];
    rate_rd <= rate_mem[scan_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.write_new) begin
      count <= count + CNT_W'(1);
    end
  end

  // scan sequencing, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
      match    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      found    <= 1'b0;
      match    <= 1'b0;
    end else begin
      if (cmd.scan_run && (scan_idx != count)) begin
        rd_vld   <= 1'b1;
        scan_idx <= scan_idx + CNT_W'(1);
      end else begin
        rd_vld <= 1'b0;
      end
      if (rd_vld && (key_rd <= qkey) && (!found || (key_rd > best_key))) begin
        found <= 1'b1;
      end
      if (rd_vld && (key_rd == qkey)) begin
        match <= 1'b1;
      end
    end
  end

  // scan payload: read address tag and best candidate
  always_ff @(posedge clk) begin
    if (cmd.scan_run) begin
      rd_addr <= scan_idx[ADDR_W-1:0];
    end
    if (rd_vld && (key_rd <= qkey) && (!found || (key_rd > best_key))) begin
      best_key  <= key_rd;
      best_rate <= rate_rd;
    end
    if (rd_vld && (key_rd == qkey)) begin
      match_addr <= rd_addr;
    end
  end

  // shared 31x32 multiplier, low then high rate slice
  assign mul_b = cmd.mul_hi ? LO_W'(best_rate[MAG_RATE_W-1:LO_W]) : best_rate[LO_W-1:0];
  assign mul_p = PLO_W'(amount_q[MAG_AMT_W-1:0]) * PLO_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      p_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      p_hi <= mul_p[PHI_W-1:0];
    end
  end

  // recombine, drop fraction, saturate
  assign full_sum = (FULL_W'(p_hi) << LO_W) + FULL_W'(p_lo);
  assign shifted  = full_sum >> FRACTION_BITS;
  assign prod_sat = (|shifted[FULL_W-1:PRODUCT_W]) ? '1 : shifted[PRODUCT_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status  <= cmd.code;
      product <= cmd.emit_product ? prod_sat : '0;
    end
  end

  // status to controller
  always_comb begin
    stat.is_query  = mode_q;
    stat.date_ok   = date_ok;
    stat.amt_neg   = amount_q[AMOUNT_W-1];
    stat.amt_big   = (amount_q[MAG_AMT_W-1:0] > max_amount);
    stat.rate_neg  = rate_q[RATE_W-1];
    stat.scan_done = (scan_idx == count) && !rd_vld;
    stat.found     = found;
    stat.match     = match;
    stat.full      = (count == CNT_W'(TABLE_DEPTH));
  end

endmodule

// File: rtl/dated_rate_floor_lookup.sv
// ----------------------------------------------------------------------------
// dated_rate_floor_lookup: date-keyed rate table with floor lookup
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. mode 0 stores
//   rate under the date (overwriting an equal date); mode 1 looks up the entry
//   with the greatest date not after the given date and returns amount * rate
//   in Q16, truncated and saturated to 49 bits.
//   Each transaction gives exactly one result: done is high for one cycle with
//   status and product valid. The receiver cannot stall; it must take it then.
//   The date and argument check comes first, and rejected inputs finish
//   there without a table scan. Otherwise the table scan reads one
//   stored entry per cycle through the single read port of each table memory,
//   covering every stored entry, up to 1024 in a full table.
//   One transaction at a time.
//   cfg_we/cfg_data write max_amount (31-bit Q16); the user must do so only
//   while idle, the block itself does not enforce it. Reset (rst, synchronous)
//   empties the table and restores max_amount to one thousand; no clearing
//   pass is needed, stored entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module dated_rate_floor_lookup import drfl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [YEAR_W-1:0]           year,
  input  logic [MONTH_W-1:0]          month,
  input  logic [DAY_W-1:0]            day,
  input  logic signed [AMOUNT_W-1:0]  amount,
  input  logic signed [RATE_W-1:0]    rate,
  input  logic                        cfg_we,
  input  logic [MAG_AMT_W-1:0]        cfg_data,
  output logic                        done,
  output logic [STATUS_W-1:0]         status,
  output logic [PRODUCT_W-1:0]        product
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  drfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table and arithmetic
  drfl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .mode     (mode),
    .year     (year),
    .month    (month),
    .day      (day),
    .amount   (amount),
    .rate     (rate),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .status   (status),
    .product  (product)
  );

  // a result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but not busy");

  // only an ok query carries a product
  a_prod_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (product == '0))
    else $error("non-zero product on failed transaction");

  // no code beyond negative rate is ever reported
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 3'd7))
    else $error("undefined status code");

  // the table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> !stat.full)
    else $error("append into full table");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: dated rate floor lookup
// Drives load and query transactions through the start/busy handshake and
// checks every done strobe against a behavioural table kept here. Directed
// date, argument and limit checks come first. A random mix over several
// max_amount settings follows.
// ----------------------------------------------------------------------------
module testbench;
  import drfl_pkg::*;

  localparam logic        MODE_LOAD    = 1'b0;
  localparam logic        MODE_QUERY   = 1'b1;
  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int          END_WAIT     = 1100;
  localparam int          RANDOM_ITEMS = 145;

  localparam logic [PRODUCT_W-1:0]  PRODUCT_SAT = '1;
  localparam logic [MAG_AMT_W-1:0]  AMOUNT_TOP  = '1;
  localparam logic [AMOUNT_W-1:0]   Q16_ONE     = 32'h0001_0000;

  typedef struct packed {
    logic                mode;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [AMOUNT_W-1:0] amount;
    logic [RATE_W-1:0]   rate;
  } rate_txn_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PRODUCT_W-1:0] product;
  } rate_result_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       mode = MODE_LOAD;
  logic [YEAR_W-1:0]          year = '0;
  logic [MONTH_W-1:0]         month = '0;
  logic [DAY_W-1:0]           day = '0;
  logic signed [AMOUNT_W-1:0] amount = '0;
  logic signed [RATE_W-1:0]   rate = '0;
  logic                       cfg_we = 1'b0;
  logic [MAG_AMT_W-1:0]       cfg_data = '0;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic [PRODUCT_W-1:0]       product;

  // behavioural copy of the table and the limit register
  logic [KEY_W-1:0]      rate_dates [TABLE_DEPTH];
  logic [MAG_RATE_W-1:0] rate_values [TABLE_DEPTH];
  int                    dated_count = 0;
  logic [MAG_AMT_W-1:0]  amount_limit = MAX_AMOUNT_RESET;

  rate_result_t due_results [$];
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int           burst_left = 0;

  dated_rate_floor_lookup u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .year     (year),
    .month    (month),
    .day      (day),
    .amount   (amount),
    .rate     (rate),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .status   (status),
    .product  (product)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- calendar
  // 31 days where bit 0 and bit 3 of the month differ, else 30; February apart
  function automatic logic [4:0] days_in(input logic [YEAR_W-1:0] y, input logic [3:0] m);
    logic leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (m == 4'd2) return leap ? 5'd29 : 5'd28;
    return 5'd30 + {4'd0, m[0] ^ m[3]};
  endfunction

  function automatic logic date_valid(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                      input logic [DAY_W-1:0] d);
    if (y < 1 || y > 9999 || m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= days_in(y, m[3:0]));
  endfunction

  // ---------------------------------------------------------------- predictor
  // floor lookup / sorted insert; updates the local table on loads
  task automatic predict_txn(input rate_txn_t t, output rate_result_t res);
    logic [KEY_W-1:0]  key;
    logic [FULL_W-1:0] wide;
    int                pos;
    res = '0;
    if (!date_valid(t.year, t.month, t.day)) begin
      res.status = ST_BAD_DATE;
    end else begin
      key = {t.year, t.month[3:0], t.day[4:0]};
      pos = 0;
      for (int i = 0; i < dated_count; i++) begin
        if (rate_dates[i] <= key) pos = i + 1;
      end
      if (t.mode == MODE_LOAD) begin
        if (t.rate[RATE_W-1]) begin
          res.status = ST_NEG_RATE;
        end else if (pos > 0 && rate_dates[pos-1] == key) begin
          rate_values[pos-1] = t.rate[MAG_RATE_W-1:0];
        end else if (dated_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = dated_count; i > pos; i--) begin
            rate_dates[i]  = rate_dates[i-1];
            rate_values[i] = rate_values[i-1];
          end
          rate_dates[pos]  = key;
          rate_values[pos] = t.rate[MAG_RATE_W-1:0];
          dated_count++;
        end
      end else begin
        if (t.amount[AMOUNT_W-1]) begin
          res.status = ST_NEG_AMOUNT;
        end else if (t.amount[MAG_AMT_W-1:0] > amount_limit) begin
          res.status = ST_TOO_LARGE;
        end else if (pos == 0) begin
          res.status = ST_NO_RATE;
        end else begin
          wide = FULL_W'(t.amount[MAG_AMT_W-1:0]) * FULL_W'(rate_values[pos-1]);
          wide = wide >> FRACTION_BITS;
          res.product = (wide > FULL_W'(PRODUCT_SAT)) ? PRODUCT_SAT : wide[PRODUCT_W-1:0];
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // each done strobe is compared against the oldest outstanding transaction
  always @(posedge clk) begin : result_check
    rate_result_t want;
    if (!rst && done === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(status), 64'(0));
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) report_mismatch("status", 64'(status), 64'(want.status));
        if (product !== want.product)
          report_mismatch("product", 64'(product), 64'(want.product));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  // one transaction; start stays high across a burst, gaps drop it
  task automatic send_txn(input rate_txn_t t);
    rate_result_t res;
    int           gap;
    int           pick;
    start  <= 1'b1;
    mode   <= t.mode;
    year   <= t.year;
    month  <= t.month;
    day    <= t.day;
    amount <= t.amount;
    rate   <= t.rate;
    do @(posedge clk); while (busy !== 1'b0);
    predict_txn(t, res);
    due_results.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      pick = $urandom_range(0, 99);
      if (pick < 25) gap = 0;
      else if (pick < 80) gap = $urandom_range(1, 4);
      else if (pick < 97) gap = $urandom_range(5, 40);
      else gap = $urandom_range(41, 1100);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop start and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_amount_limit(input logic [MAG_AMT_W-1:0] value);
    settle();
    while (busy !== 1'b0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    amount_limit = value;
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic rate_txn_t make_txn(input logic md, input int y, input int m, input int d,
                                         input logic [AMOUNT_W-1:0] amt,
                                         input logic [RATE_W-1:0] r);
    rate_txn_t t;
    t.mode   = md;
    t.year   = YEAR_W'(y);
    t.month  = MONTH_W'(m);
    t.day    = DAY_W'(d);
    t.amount = amt;
    t.rate   = r;
    return t;
  endfunction

  // non-negative rate spread over all magnitudes
  function automatic logic [RATE_W-1:0] random_rate();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    raw = raw >> $urandom_range(25, 63);
    return {1'b0, raw[MAG_RATE_W-1:0]};
  endfunction

  // well-formed transaction: valid date, accepted amount, non-negative rate
  function automatic rate_txn_t random_dated_txn(input logic md);
    rate_txn_t t;
    t.mode   = md;
    t.year   = YEAR_W'($urandom_range(1, 9999));
    t.month  = MONTH_W'($urandom_range(1, 12));
    t.day    = DAY_W'($urandom_range(1, days_in(t.year, t.month[3:0])));
    t.amount = {1'b0, MAG_AMT_W'($urandom_range(0, amount_limit))};
    if ($urandom_range(0, 3) == 0) t.amount = t.amount >> $urandom_range(0, 30);
    else if ($urandom_range(0, 15) == 0) t.amount = {1'b0, amount_limit};
    t.rate = random_rate();
    return t;
  endfunction

  function automatic rate_txn_t random_txn();
    rate_txn_t        t;
    logic [KEY_W-1:0] key;
    int               pick;
    pick = $urandom_range(0, 99);
    t = random_dated_txn((pick < 40) ? MODE_LOAD : MODE_QUERY);
    // aim at stored dates: exact hits, or the same year
    if (dated_count > 0 && $urandom_range(0, 2) != 0) begin
      key = rate_dates[$urandom_range(0, dated_count - 1)];
      t.year = key[KEY_W-1:9];
      if ($urandom_range(0, 1) == 1) begin
        t.month = MONTH_W'(key[8:5]);
        t.day   = DAY_W'(key[4:0]);
      end else begin
        t.day = DAY_W'($urandom_range(1, days_in(t.year, t.month[3:0])));
      end
    end
    if (pick >= 80 && pick < 88) begin
      t.amount = $urandom | 32'h8000_0000;
      t.rate   = random_rate();
      t.rate[RATE_W-1] = 1'b1;
    end else if (pick >= 88 && pick < 92) begin
      t.mode = MODE_QUERY;
      if (amount_limit != AMOUNT_TOP)
        t.amount = AMOUNT_W'($urandom_range(32'(amount_limit) + 1, 32'h7FFF_FFFF));
    end else if (pick >= 92) begin
      // noise over the whole field ranges
      t.mode   = 1'($urandom_range(0, 1));
      t.year   = YEAR_W'($urandom_range(0, 16383));
      t.month  = MONTH_W'($urandom_range(0, 127));
      t.day    = DAY_W'($urandom_range(0, 127));
      t.amount = $urandom;
      t.rate   = RATE_W'({$urandom, $urandom});
    end
    return t;
  endfunction

  // ---------------------------------------------------------------- tests
  // date validation, load order of checks, overwrite; table starts empty
  task automatic test_date_checks();
    send_txn(make_txn(MODE_QUERY, 2024, 2, 29, Q16_ONE, '0));       // empty table
    send_txn(make_txn(MODE_LOAD, 0, 1, 1, '0, 40'h1_0000));
    send_txn(make_txn(MODE_LOAD, 2023, 13, 1, '0, 40'h1_0000));
    send_txn(make_txn(MODE_LOAD, 2023, 1, 0, '0, 40'h1_0000));
    send_txn(make_txn(MODE_LOAD, 2023, 1, 32, '0, 40'h1_0000));
    send_txn(make_txn(MODE_LOAD, 2023, 4, 31, '0, 40'h1_0000));
    send_txn(make_txn(MODE_LOAD, 2023, 2, 29, '0, 40'h1_0000));     // not leap
    send_txn(make_txn(MODE_LOAD, 1900, 2, 29, '0, 40'h1_0000));     // century
    send_txn(make_txn(MODE_LOAD, 2000, 2, 29, '0, 40'h1_8000));     // 400 rule, 1.5
    send_txn(make_txn(MODE_LOAD, 2024, 2, 29, '0, 40'h2_0000));     // 2.0
    send_txn(make_txn(MODE_LOAD, 1, 1, 1, '0, '0));
    send_txn(make_txn(MODE_LOAD, 9999, 12, 31, '0, 40'h7F_FFFF_FFFF));
    send_txn(make_txn(MODE_LOAD, 10000, 1, 1, '0, 40'h1_0000));
    // bad date wins over a negative rate
    send_txn(make_txn(MODE_LOAD, 16383, 127, 127, '1, '1));
    send_txn(make_txn(MODE_LOAD, 2010, 6, 15, '0, 40'h80_0000_0000));
    send_txn(make_txn(MODE_LOAD, 2000, 2, 29, '0, 40'h3_4000));     // overwrite, 3.25
  endtask

  // floor lookup and query order of checks
  task automatic test_query_checks();
    send_txn(make_txn(MODE_QUERY, 2000, 3, 1, 32'h000A_0000, '0));
    send_txn(make_txn(MODE_QUERY, 2024, 2, 29, {1'b0, amount_limit}, '0));
    send_txn(make_txn(MODE_QUERY, 2023, 12, 31, '0, '0));
    send_txn(make_txn(MODE_QUERY, 2010, 5, 5, 32'hFFFF_FFFF, '0));
    send_txn(make_txn(MODE_QUERY, 2010, 5, 5, 32'h8000_0000, '0));
    send_txn(make_txn(MODE_QUERY, 2010, 13, 5, 32'h8000_0000, '0));
    send_txn(make_txn(MODE_QUERY, 2010, 5, 5, {1'b0, amount_limit} + 1, '0));
  endtask

  // max_amount extremes, including product saturation
  task automatic test_amount_limit();
    set_amount_limit('0);
    send_txn(make_txn(MODE_QUERY, 2010, 5, 5, '0, '0));
    send_txn(make_txn(MODE_QUERY, 2010, 5, 5, 32'd1, '0));
    set_amount_limit(AMOUNT_TOP);
    send_txn(make_txn(MODE_QUERY, 9999, 12, 31, 32'h7FFF_FFFF, '0));
    send_txn(make_txn(MODE_QUERY, 2024, 3, 1, 32'h7FFF_FFFF, '0));
    set_amount_limit(MAX_AMOUNT_RESET);
  endtask

  // random transactions over several limit settings
  task automatic test_random_mix();
    logic [MAG_AMT_W-1:0] limits [4];
    limits[0] = MAX_AMOUNT_RESET;
    limits[1] = MAG_AMT_W'($urandom);
    limits[2] = AMOUNT_TOP;
    limits[3] = MAG_AMT_W'($urandom_range(0, 32'h0001_0000));
    for (int p = 0; p < 4; p++) begin
      set_amount_limit(limits[p]);
      for (int n = 0; n < RANDOM_ITEMS; n++) send_txn(random_txn());
    end
    set_amount_limit(MAX_AMOUNT_RESET);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_date_checks();
    test_query_checks();
    test_amount_limit();
    test_random_mix();
    settle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/drfl_pkg.sv
rtl/drfl_ctrl.sv
rtl/drfl_datapath.sv
rtl/dated_rate_floor_lookup.sv
dv/testbench.sv
